@@ rtl/face_flat_shade_light_unit_macros.svh @@
// Assertion macros shared by the face flat shade light unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef FACE_FLAT_SHADE_LIGHT_UNIT_MACROS_SVH
`define FACE_FLAT_SHADE_LIGHT_UNIT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define FFSL_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Condition implies a consequence in the next cycle.
`define FFSL_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/ffsl_pkg.sv @@
// Shared constants and types of the face flat shade light unit.
// No dependencies; used by the top level and the light pipeline.
`timescale 1ns / 1ps

package ffsl_pkg;

    // Default parameter values.
    localparam int VERTEX_DEPTH_DEF = 1024;
    localparam int COORD_WIDTH_DEF  = 16;

    // Field widths fixed by the interface.
    localparam int SLOT_W  = 10;
    localparam int LEVEL_W = 16;

    // Q1.15 level format.
    localparam int LEVEL_FRAC = 15;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 16'h8000;

    // Register reset values (0.4 and 0.6 in Q1.15).
    localparam logic [LEVEL_W-1:0] LIGHT_SCALE_RESET = 16'd13107;
    localparam logic [LEVEL_W-1:0] LIGHT_BIAS_RESET  = 16'd19661;

    // Edge magnitudes are kept below 2^EDGE_BITS, normal magnitudes below 2^RED_BITS.
    localparam int EDGE_BITS = 30;
    localparam int RED_BITS  = 24;

    // Configuration handed to the light pipeline.
    typedef struct packed {
        logic [LEVEL_W-1:0] scale;
        logic [LEVEL_W-1:0] bias;
    } cfg_t;

endpackage

@@ rtl/ffsl_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module ffsl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, held while disabled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/ffsl_light_pipe.sv @@
// Light pipeline: edge reduction, cross product, normal length, cosine, level.
// Depends on ffsl_pkg.
`timescale 1ns / 1ps

module ffsl_light_pipe #(
    parameter int COORD_WIDTH = ffsl_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ffsl_pkg::cfg_t                      cfg,
    input  logic                                edge_valid,
    output logic                                edge_ready,
    input  logic signed [COORD_WIDTH:0]         ux,
    input  logic signed [COORD_WIDTH:0]         uy,
    input  logic signed [COORD_WIDTH:0]         uz,
    input  logic signed [COORD_WIDTH:0]         vx,
    input  logic signed [COORD_WIDTH:0]         vy,
    input  logic signed [COORD_WIDTH:0]         vz,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [ffsl_pkg::LEVEL_W-1:0]        light_level,
    output logic                                degenerate
);

    // Widths.
    localparam int EW     = COORD_WIDTH + 1;
    localparam int RW     = (EW > ffsl_pkg::EDGE_BITS + 1) ? ffsl_pkg::EDGE_BITS + 1 : EW;
    localparam int EKW    = $clog2(EW + 1);
    localparam int PW     = 2 * RW;
    localparam int NW     = PW + 1;
    localparam int RB     = ffsl_pkg::RED_BITS;
    localparam int NMW    = (NW > RB) ? NW : RB;
    localparam int KW     = $clog2(NMW + 1);
    localparam int SQW    = 2 * RB;
    localparam int SUM_W  = SQW + 2;
    localparam int LEN_W  = SUM_W / 2;
    localparam int REM_W  = LEN_W + 2;
    localparam int Q_W    = ffsl_pkg::LEVEL_FRAC + 1;
    localparam int LW     = ffsl_pkg::LEVEL_W;

    // Iterative units unrolled two steps per stage.
    localparam int SQ_PER     = 2;
    localparam int SQ_STAGES  = (LEN_W + SQ_PER - 1) / SQ_PER;
    localparam int DV_PER     = 2;
    localparam int DV_STAGES  = (Q_W + DV_PER - 1) / DV_PER;

    // Stage indexes.
    localparam int K_RED = 0;
    localparam int K_MUL = 1;
    localparam int K_NRM = 2;
    localparam int K_MAG = 3;
    localparam int K_SHF = 4;
    localparam int K_SQR = 5;
    localparam int K_SUM = 6;
    localparam int K_SQ0 = 7;
    localparam int K_DV0 = K_SQ0 + SQ_STAGES;
    localparam int K_PRD = K_DV0 + DV_STAGES;
    localparam int K_OUT = K_PRD + 1;
    localparam int NST   = K_OUT + 1;

    localparam logic [LW+2:0] ROUND_HALF = (LW + 3)'(1 << (ffsl_pkg::LEVEL_FRAC - 1));

    // ------------------------------------------------------------------
    // Valid bits and stage enables; a stage loads when any stage at or
    // after it is empty or the output is not stalled.
    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;
    logic [NST-1:0] v_in;

    genvar g;
    generate
        for (g = 0; g < NST; g++)
        begin : g_en
            assign en[g] = !result_stall || !(&v_reg[NST-1:g]);
        end
    endgenerate

    assign v_in       = {v_reg[NST-2:0], edge_valid};
    assign edge_ready = en[K_RED];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= (en & v_in) | (~en & v_reg);
        end
    end

    // ------------------------------------------------------------------
    // Edge reduction: scale every component of u and v by one common power of two so
    // every magnitude stays below the edge limit.
    logic signed [EW-1:0] e_in [6];
    logic signed [RW-1:0] red_next [6];
    logic signed [RW-1:0] red_reg [6];

    assign e_in[0] = ux;
    assign e_in[1] = uy;
    assign e_in[2] = uz;
    assign e_in[3] = vx;
    assign e_in[4] = vy;
    assign e_in[5] = vz;

    always_comb
    begin
        logic [EW-1:0]  em [6];
        logic [EW-1:0]  eor;
        logic [EW-1:0]  sh;
        logic [RW-1:0]  sm;
        logic [EKW-1:0] ek;
        eor = '0;
        for (int i = 0; i < 6; i++)
        begin
            em[i] = e_in[i][EW-1] ? EW'(-e_in[i]) : EW'(e_in[i]);
            eor   = eor | em[i];
        end
        ek = '0;
        for (int b = ffsl_pkg::EDGE_BITS; b < EW; b++)
        begin
            if (eor[b])
            begin
                ek = EKW'(b - ffsl_pkg::EDGE_BITS + 1);
            end
        end
        for (int i = 0; i < 6; i++)
        begin
            sh          = em[i] >> ek;
            sm          = sh[RW-1:0];
            red_next[i] = e_in[i][EW-1] ? -$signed(sm) : $signed(sm);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[K_RED])
        begin
            red_reg <= red_next;
        end
    end

    // ------------------------------------------------------------------
    // Cross product partial products: u = red[0..2], v = red[3..5].
    logic signed [PW-1:0] prod_reg [6];

    always_ff @(posedge clk)
    begin
        if (en[K_MUL])
        begin
            prod_reg[0] <= PW'(red_reg[1]) * PW'(red_reg[5]);
            prod_reg[1] <= PW'(red_reg[2]) * PW'(red_reg[4]);
            prod_reg[2] <= PW'(red_reg[2]) * PW'(red_reg[3]);
            prod_reg[3] <= PW'(red_reg[0]) * PW'(red_reg[5]);
            prod_reg[4] <= PW'(red_reg[0]) * PW'(red_reg[4]);
            prod_reg[5] <= PW'(red_reg[1]) * PW'(red_reg[3]);
        end
    end

    // Normal components.
    logic signed [NW-1:0] nrm_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[K_NRM])
        begin
            nrm_reg[0] <= NW'(prod_reg[0]) - NW'(prod_reg[1]);
            nrm_reg[1] <= NW'(prod_reg[2]) - NW'(prod_reg[3]);
            nrm_reg[2] <= NW'(prod_reg[4]) - NW'(prod_reg[5]);
        end
    end

    // ------------------------------------------------------------------
    // Normal magnitudes, zero-length test and reduction shift count.
    logic [NMW-1:0] mag_next [3];
    logic [NMW-1:0] mag_reg  [3];
    logic [KW-1:0]  nk_next;
    logic [KW-1:0]  nk_reg;
    logic           deg_next;
    logic           mag_deg_reg;
    logic           mag_neg_reg;

    always_comb
    begin
        logic signed [NMW-1:0] nw;
        logic [NMW-1:0]        nor_v;
        nor_v = '0;
        for (int i = 0; i < 3; i++)
        begin
            nw          = NMW'(nrm_reg[i]);
            mag_next[i] = nw[NMW-1] ? NMW'(-nw) : NMW'(nw);
            nor_v       = nor_v | mag_next[i];
        end
        deg_next = (nor_v == '0);
        nk_next  = '0;
        for (int b = RB; b < NMW; b++)
        begin
            if (nor_v[b])
            begin
                nk_next = KW'(b - RB + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[K_MAG])
        begin
            mag_reg     <= mag_next;
            nk_reg      <= nk_next;
            mag_deg_reg <= deg_next;
            mag_neg_reg <= nrm_reg[2][NW-1];
        end
    end

    // Reduced magnitudes.
    logic [RB-1:0] rm_reg [3];
    logic          shf_deg_reg;
    logic          shf_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[K_SHF])
        begin
            for (int i = 0; i < 3; i++)
            begin
                rm_reg[i] <= RB'(mag_reg[i] >> nk_reg);
            end
            shf_deg_reg <= mag_deg_reg;
            shf_neg_reg <= mag_neg_reg;
        end
    end

    // Squares.
    logic [SQW-1:0] sq_reg [3];
    logic [RB-1:0]  sqr_nz_reg;
    logic           sqr_deg_reg;
    logic           sqr_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[K_SQR])
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQW'(rm_reg[i]) * SQW'(rm_reg[i]);
            end
            sqr_nz_reg  <= rm_reg[2];
            sqr_deg_reg <= shf_deg_reg;
            sqr_neg_reg <= shf_neg_reg;
        end
    end

    // Sum of squares.
    logic [SUM_W-1:0] sum_reg;
    logic [RB-1:0]    sum_nz_reg;
    logic             sum_deg_reg;
    logic             sum_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[K_SUM])
        begin
            sum_reg     <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sum_nz_reg  <= sqr_nz_reg;
            sum_deg_reg <= sqr_deg_reg;
            sum_neg_reg <= sqr_neg_reg;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, two result bits per stage.
    logic [SUM_W-1:0] sq_rad_in  [SQ_STAGES];
    logic [REM_W-1:0] sq_rem_in  [SQ_STAGES];
    logic [LEN_W-1:0] sq_root_in [SQ_STAGES];
    logic [RB-1:0]    sq_nz_in   [SQ_STAGES];
    logic             sq_deg_in  [SQ_STAGES];
    logic             sq_neg_in  [SQ_STAGES];
    logic [SUM_W-1:0] sq_rad_next  [SQ_STAGES];
    logic [REM_W-1:0] sq_rem_next  [SQ_STAGES];
    logic [LEN_W-1:0] sq_root_next [SQ_STAGES];
    logic [SUM_W-1:0] sq_rad_reg   [SQ_STAGES];
    logic [REM_W-1:0] sq_rem_reg   [SQ_STAGES];
    logic [LEN_W-1:0] sq_root_reg  [SQ_STAGES];
    logic [RB-1:0]    sq_nz_reg    [SQ_STAGES];
    logic             sq_deg_reg   [SQ_STAGES];
    logic             sq_neg_reg   [SQ_STAGES];

    generate
        for (g = 0; g < SQ_STAGES; g++)
        begin : g_sqrt
            if (g == 0)
            begin : g_first
                assign sq_rad_in[g]  = sum_reg;
                assign sq_rem_in[g]  = '0;
                assign sq_root_in[g] = '0;
                assign sq_nz_in[g]   = sum_nz_reg;
                assign sq_deg_in[g]  = sum_deg_reg;
                assign sq_neg_in[g]  = sum_neg_reg;
            end
            else
            begin : g_next
                assign sq_rad_in[g]  = sq_rad_reg[g-1];
                assign sq_rem_in[g]  = sq_rem_reg[g-1];
                assign sq_root_in[g] = sq_root_reg[g-1];
                assign sq_nz_in[g]   = sq_nz_reg[g-1];
                assign sq_deg_in[g]  = sq_deg_reg[g-1];
                assign sq_neg_in[g]  = sq_neg_reg[g-1];
            end

            always_comb
            begin
                logic [SUM_W-1:0] rad;
                logic [REM_W-1:0] rem;
                logic [LEN_W-1:0] root;
                logic [REM_W+1:0] rt;
                logic [REM_W+1:0] tr;
                rad  = sq_rad_in[g];
                rem  = sq_rem_in[g];
                root = sq_root_in[g];
                for (int j = 0; j < SQ_PER; j++)
                begin
                    if (g * SQ_PER + j < LEN_W)
                    begin
                        rt  = {rem, rad[SUM_W-1 -: 2]};
                        tr  = {2'b00, root, 2'b01};
                        rad = rad << 2;
                        if (rt >= tr)
                        begin
                            rem  = REM_W'(rt - tr);
                            root = {root[LEN_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem  = REM_W'(rt);
                            root = {root[LEN_W-2:0], 1'b0};
                        end
                    end
                end
                sq_rad_next[g]  = rad;
                sq_rem_next[g]  = rem;
                sq_root_next[g] = root;
            end

            always_ff @(posedge clk)
            begin
                if (en[K_SQ0 + g])
                begin
                    sq_rad_reg[g]  <= sq_rad_next[g];
                    sq_rem_reg[g]  <= sq_rem_next[g];
                    sq_root_reg[g] <= sq_root_next[g];
                    sq_nz_reg[g]   <= sq_nz_in[g];
                    sq_deg_reg[g]  <= sq_deg_in[g];
                    sq_neg_reg[g]  <= sq_neg_in[g];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Cosine quotient |nz| * 2^15 / len, restoring division, two bits per stage.
    logic [LEN_W-1:0] dv_rem_in  [DV_STAGES];
    logic [Q_W-1:0]   dv_nb_in   [DV_STAGES];
    logic [Q_W-1:0]   dv_q_in    [DV_STAGES];
    logic [LEN_W-1:0] dv_len_in  [DV_STAGES];
    logic             dv_deg_in  [DV_STAGES];
    logic             dv_neg_in  [DV_STAGES];
    logic [LEN_W-1:0] dv_rem_next [DV_STAGES];
    logic [Q_W-1:0]   dv_nb_next  [DV_STAGES];
    logic [Q_W-1:0]   dv_q_next   [DV_STAGES];
    logic [LEN_W-1:0] dv_rem_reg  [DV_STAGES];
    logic [Q_W-1:0]   dv_nb_reg   [DV_STAGES];
    logic [Q_W-1:0]   dv_q_reg    [DV_STAGES];
    logic [LEN_W-1:0] dv_len_reg  [DV_STAGES];
    logic             dv_deg_reg  [DV_STAGES];
    logic             dv_neg_reg  [DV_STAGES];

    generate
        for (g = 0; g < DV_STAGES; g++)
        begin : g_div
            if (g == 0)
            begin : g_first
                assign dv_rem_in[g] = LEN_W'(sq_nz_reg[SQ_STAGES-1] >> 1);
                assign dv_nb_in[g]  = {sq_nz_reg[SQ_STAGES-1][0], (Q_W-1)'(0)};
                assign dv_q_in[g]   = '0;
                assign dv_len_in[g] = sq_root_reg[SQ_STAGES-1];
                assign dv_deg_in[g] = sq_deg_reg[SQ_STAGES-1];
                assign dv_neg_in[g] = sq_neg_reg[SQ_STAGES-1];
            end
            else
            begin : g_next
                assign dv_rem_in[g] = dv_rem_reg[g-1];
                assign dv_nb_in[g]  = dv_nb_reg[g-1];
                assign dv_q_in[g]   = dv_q_reg[g-1];
                assign dv_len_in[g] = dv_len_reg[g-1];
                assign dv_deg_in[g] = dv_deg_reg[g-1];
                assign dv_neg_in[g] = dv_neg_reg[g-1];
            end

            always_comb
            begin
                logic [LEN_W-1:0] rem;
                logic [Q_W-1:0]   nb;
                logic [Q_W-1:0]   q;
                logic [LEN_W:0]   t;
                rem = dv_rem_in[g];
                nb  = dv_nb_in[g];
                q   = dv_q_in[g];
                for (int j = 0; j < DV_PER; j++)
                begin
                    if (g * DV_PER + j < Q_W)
                    begin
                        t  = {rem, nb[Q_W-1]};
                        nb = nb << 1;
                        if (t >= {1'b0, dv_len_in[g]})
                        begin
                            rem = LEN_W'(t - {1'b0, dv_len_in[g]});
                            q   = {q[Q_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem = LEN_W'(t);
                            q   = {q[Q_W-2:0], 1'b0};
                        end
                    end
                end
                dv_rem_next[g] = rem;
                dv_nb_next[g]  = nb;
                dv_q_next[g]   = q;
            end

            always_ff @(posedge clk)
            begin
                if (en[K_DV0 + g])
                begin
                    dv_rem_reg[g] <= dv_rem_next[g];
                    dv_nb_reg[g]  <= dv_nb_next[g];
                    dv_q_reg[g]   <= dv_q_next[g];
                    dv_len_reg[g] <= dv_len_in[g];
                    dv_deg_reg[g] <= dv_deg_in[g];
                    dv_neg_reg[g] <= dv_neg_in[g];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Gain product.
    logic [2*LW-1:0] gain_reg;
    logic            prd_deg_reg;
    logic            prd_neg_reg;

    always_ff @(posedge clk)
    begin
        if (en[K_PRD])
        begin
            gain_reg    <= (2*LW)'(cfg.scale) * (2*LW)'(dv_q_reg[DV_STAGES-1]);
            prd_deg_reg <= dv_deg_reg[DV_STAGES-1];
            prd_neg_reg <= dv_neg_reg[DV_STAGES-1];
        end
    end

    // Rounding, bias, clamp and the output register.
    logic [LW-1:0] level_next;
    logic [LW-1:0] level_reg;
    logic          deg_reg;

    always_comb
    begin
        logic [2*LW:0]        rsum;
        logic [LW+1:0]        r;
        logic signed [LW+2:0] lv;
        rsum = {1'b0, gain_reg} + (2*LW+1)'(ROUND_HALF);
        r    = rsum[2*LW:ffsl_pkg::LEVEL_FRAC];
        if (prd_neg_reg)
        begin
            lv = $signed((LW+3)'(cfg.bias)) - $signed((LW+3)'(r));
        end
        else
        begin
            lv = $signed((LW+3)'(cfg.bias)) + $signed((LW+3)'(r));
        end
        if (prd_deg_reg)
        begin
            level_next = (cfg.bias > ffsl_pkg::LEVEL_ONE) ? ffsl_pkg::LEVEL_ONE : cfg.bias;
        end
        else if (lv[LW+2])
        begin
            level_next = '0;
        end
        else if (lv > $signed((LW+3)'(ffsl_pkg::LEVEL_ONE)))
        begin
            level_next = ffsl_pkg::LEVEL_ONE;
        end
        else
        begin
            level_next = LW'(lv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[K_OUT])
        begin
            level_reg <= level_next;
            deg_reg   <= prd_deg_reg;
        end
    end

    assign result_valid = v_reg[K_OUT];
    assign light_level  = level_reg;
    assign degenerate   = deg_reg;

endmodule

@@ rtl/face_flat_shade_light_unit.sv @@
// Top level of the face flat shade light unit: register port, vertex stores, edges.
// Depends on ffsl_pkg, ffsl_ram, ffsl_light_pipe and the assertion macro header.
//
//   channel   direction  handshake                  payload
//   item      in         item_valid / item_stall    op, vertex_slot, coord_x/y/z, corner_a/b/c
//   result    out        result_valid / result_stall light_level, degenerate
//   config    in         psel / penable / pwrite    paddr, pwdata, prdata (pready tied high)
//
// One transaction is accepted per cycle while item_stall is low; a shade transaction
// passes 3 front stages and 30 light pipeline stages to the result port at the default
// coordinate width, mostly square root and divide stages at two bits per stage. Vertex
// writes give no result. The three vertex store copies take one write and one read each
// per cycle while the store read stage is enabled. Reset clears only the valid bits and
// the config registers. A stall holds a full stage only if every stage after it is full.
`timescale 1ns / 1ps
`include "face_flat_shade_light_unit_macros.svh"

module face_flat_shade_light_unit #(
    parameter int VERTEX_DEPTH = ffsl_pkg::VERTEX_DEPTH_DEF,
    parameter int COORD_WIDTH  = ffsl_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic                               op,
    input  logic [ffsl_pkg::SLOT_W-1:0]        vertex_slot,
    input  logic signed [COORD_WIDTH-1:0]      coord_x,
    input  logic signed [COORD_WIDTH-1:0]      coord_y,
    input  logic signed [COORD_WIDTH-1:0]      coord_z,
    input  logic [ffsl_pkg::SLOT_W-1:0]        corner_a,
    input  logic [ffsl_pkg::SLOT_W-1:0]        corner_b,
    input  logic [ffsl_pkg::SLOT_W-1:0]        corner_c,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [ffsl_pkg::LEVEL_W-1:0]       light_level,
    output logic                               degenerate
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam int CW = COORD_WIDTH;
    localparam int EW = CW + 1;
    localparam int VW = 3 * CW;
    localparam int SW = ffsl_pkg::SLOT_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SHADE  = 1'b1;
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_BIAS  = 1'b1;

    // Slot number modulo the store depth by restoring subtraction.
    function automatic logic [AW-1:0] slot_mod(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = s;
        for (int j = 8; j >= 0; j--)
        begin
            if (32'(r) >= 32'(VERTEX_DEPTH << j))
            begin
                r = r - SW'(VERTEX_DEPTH << j);
            end
        end
        return AW'(r);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    logic [ffsl_pkg::LEVEL_W-1:0] light_scale_reg;
    logic [ffsl_pkg::LEVEL_W-1:0] light_bias_reg;
    logic                         cfg_write;
    ffsl_pkg::cfg_t               cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_scale_reg <= ffsl_pkg::LIGHT_SCALE_RESET;
            light_bias_reg  <= ffsl_pkg::LIGHT_BIAS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SCALE: light_scale_reg <= pwdata[15:0];
                REG_BIAS:  light_bias_reg  <= pwdata[15:0];
                default:   light_bias_reg  <= light_bias_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SCALE: prdata = {16'b0, light_scale_reg};
            REG_BIAS:  prdata = {16'b0, light_bias_reg};
            default:   prdata = '0;
        endcase
    end

    assign cfg.scale = light_scale_reg;
    assign cfg.bias  = light_bias_reg;

    // ------------------------------------------------------------------
    // Stage enables: input stage, store read stage, edge stage.
    logic v_in_reg;
    logic v_ram_reg;
    logic v_edge_reg;
    logic en_in;
    logic en_ram;
    logic en_edge;
    logic core_ready;

    // Input stage payload.
    logic          op_in_reg;
    logic [AW-1:0] wslot_in_reg;
    logic [VW-1:0] vert_in_reg;
    logic [AW-1:0] ca_in_reg;
    logic [AW-1:0] cb_in_reg;
    logic [AW-1:0] cc_in_reg;

    assign en_edge    = !v_edge_reg || core_ready;
    assign en_ram     = !v_ram_reg || en_edge;
    assign en_in      = !v_in_reg || en_ram;
    assign item_stall = !en_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_in_reg   <= 1'b0;
            v_ram_reg  <= 1'b0;
            v_edge_reg <= 1'b0;
        end
        else
        begin
            if (en_in)
            begin
                v_in_reg <= item_valid;
            end
            if (en_ram)
            begin
                v_ram_reg <= v_in_reg && (op_in_reg == OP_SHADE);
            end
            if (en_edge)
            begin
                v_edge_reg <= v_ram_reg;
            end
        end
    end

    // Input stage: slot reduction and payload capture.
    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            op_in_reg    <= op;
            wslot_in_reg <= slot_mod(vertex_slot);
            vert_in_reg  <= {coord_x, coord_y, coord_z};
            ca_in_reg    <= slot_mod(corner_a);
            cb_in_reg    <= slot_mod(corner_b);
            cc_in_reg    <= slot_mod(corner_c);
        end
    end

    // ------------------------------------------------------------------
    // Three copies of the vertex store, one per face corner.
    logic          ram_we;
    logic [VW-1:0] va_data;
    logic [VW-1:0] vb_data;
    logic [VW-1:0] vc_data;

    assign ram_we = en_ram && v_in_reg && (op_in_reg == OP_WRITE);

    ffsl_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_store_a (
        .clk   (clk),
        .en    (en_ram),
        .we    (ram_we),
        .waddr (wslot_in_reg),
        .wdata (vert_in_reg),
        .raddr (ca_in_reg),
        .rdata (va_data)
    );

    ffsl_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_store_b (
        .clk   (clk),
        .en    (en_ram),
        .we    (ram_we),
        .waddr (wslot_in_reg),
        .wdata (vert_in_reg),
        .raddr (cb_in_reg),
        .rdata (vb_data)
    );

    ffsl_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_store_c (
        .clk   (clk),
        .en    (en_ram),
        .we    (ram_we),
        .waddr (wslot_in_reg),
        .wdata (vert_in_reg),
        .raddr (cc_in_reg),
        .rdata (vc_data)
    );

    // ------------------------------------------------------------------
    // Edge stage: u = b - a, v = c - a.
    logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic signed [EW-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;

    assign ax = va_data[VW-1:2*CW];
    assign ay = va_data[2*CW-1:CW];
    assign az = va_data[CW-1:0];
    assign bx = vb_data[VW-1:2*CW];
    assign by = vb_data[2*CW-1:CW];
    assign bz = vb_data[CW-1:0];
    assign cx = vc_data[VW-1:2*CW];
    assign cy = vc_data[2*CW-1:CW];
    assign cz = vc_data[CW-1:0];

    always_ff @(posedge clk)
    begin
        if (en_edge)
        begin
            ux_reg <= EW'(bx) - EW'(ax);
            uy_reg <= EW'(by) - EW'(ay);
            uz_reg <= EW'(bz) - EW'(az);
            vx_reg <= EW'(cx) - EW'(ax);
            vy_reg <= EW'(cy) - EW'(ay);
            vz_reg <= EW'(cz) - EW'(az);
        end
    end

    // ------------------------------------------------------------------
    // Normal, cosine and level pipeline.
    ffsl_light_pipe #(.COORD_WIDTH(COORD_WIDTH)) u_light_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .edge_valid   (v_edge_reg),
        .edge_ready   (core_ready),
        .ux           (ux_reg),
        .uy           (uy_reg),
        .uz           (uz_reg),
        .vx           (vx_reg),
        .vy           (vy_reg),
        .vz           (vz_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .light_level  (light_level),
        .degenerate   (degenerate)
    );

    // ------------------------------------------------------------------
    // Assertions.
    `FFSL_ASSERT_IMPL(a_stall_only_when_full, item_stall, v_in_reg && v_ram_reg && v_edge_reg, "input stalled with an empty front stage")
    `FFSL_ASSERT_NEXT(a_edge_held, v_edge_reg && !core_ready, v_edge_reg, "stalled edge transaction was dropped")
    `FFSL_ASSERT_NEXT(a_bias_write, cfg_write && (paddr[2] == REG_BIAS), light_bias_reg == $past(pwdata[15:0]), "bias register write lost")

endmodule

@@ tb/face_flat_shade_light_unit_tb.sv @@
// Testbench of the face flat shade light unit: vertex writes and face shading.
// A scoreboard class predicts each face light level; depends on ffsl_pkg and the RTL.
`timescale 1ns / 1ps

module face_flat_shade_light_unit_tb;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SHADE = 1'b1;
    localparam logic [2:0] REG_SCALE = 3'd0;
    localparam logic [2:0] REG_BIAS  = 3'd4;
    localparam int NUM_SLOTS = 1024;

    typedef struct {
        logic [ffsl_pkg::LEVEL_W-1:0] level;
        logic                         degen;
    } shade_t;

    // Face light predictor with its own vertex store and light registers.
    class face_light_board;
        int signed vx[NUM_SLOTS];
        int signed vy[NUM_SLOTS];
        int signed vz[NUM_SLOTS];
        int        scale;
        int        bias;
        shade_t    pending[$];
        int        errors;

        function void reset_regs();
            scale = ffsl_pkg::LIGHT_SCALE_RESET;
            bias  = ffsl_pkg::LIGHT_BIAS_RESET;
        endfunction

        function longint unsigned root(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n   -= res + bitv;
                    res  = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        function longint clamp(longint v);
            if (v < 0) return 0;
            if (v > 32768) return 32768;
            return v;
        endfunction

        // Notes an accepted transaction; a shade transaction queues its level.
        function void note_item(logic opv, int slot, int x, int y, int z,
                                int a, int b, int c);
            longint ux, uy, uz, wx, wy, wz, nx, ny, nz, m, dv;
            longint unsigned len, cmag, r;
            shade_t e;
            if (opv == OP_WRITE)
            begin
                vx[slot] = x;
                vy[slot] = y;
                vz[slot] = z;
                return;
            end
            ux = vx[b] - vx[a];
            uy = vy[b] - vy[a];
            uz = vz[b] - vz[a];
            wx = vx[c] - vx[a];
            wy = vy[c] - vy[a];
            wz = vz[c] - vz[a];
            // Edges of 16-bit coordinates stay well below 2^30, so no edge scaling.
            nx = uy * wz - uz * wy;
            ny = uz * wx - ux * wz;
            nz = ux * wy - uy * wx;
            e.degen = 0;
            if (nx == 0 && ny == 0 && nz == 0)
            begin
                e.degen = 1;
                e.level = 16'(clamp(bias));
            end
            else
            begin
                m = (nx < 0) ? -nx : nx;
                if ((ny < 0 ? -ny : ny) > m) m = (ny < 0) ? -ny : ny;
                if ((nz < 0 ? -nz : nz) > m) m = (nz < 0) ? -nz : nz;
                dv = 1;
                while ((m / dv) >= (64'd1 << ffsl_pkg::RED_BITS)) dv *= 2;
                nx /= dv;
                ny /= dv;
                nz /= dv;
                len = root(nx * nx + ny * ny + nz * nz);
                if (len == 0) len = 1;
                cmag = ((nz < 0) ? -nz : nz) * 32768 / len;
                if (cmag > 32768) cmag = 32768;
                r = (scale * cmag + 16384) >> 15;
                e.level = (nz >= 0) ? 16'(clamp(bias + longint'(r)))
                                    : 16'(clamp(bias - longint'(r)));
            end
            pending.insert(pending.size(), e);
        endfunction

        task report(string what, int got, int want);
            $display("level check: %s got %0d expected %0d at %0t", what, got, want, $time);
            errors++;
        endtask

        // Compares one result transaction with the oldest expected level.
        task check_result(logic [ffsl_pkg::LEVEL_W-1:0] lvl, logic dg);
            shade_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", lvl, -1);
                return;
            end
            e = pending.pop_front();
            if (lvl !== e.level) report("light_level", lvl, e.level);
            if (dg !== e.degen) report("degenerate", dg, e.degen);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic item_valid, item_stall;
    logic op;
    logic [ffsl_pkg::SLOT_W-1:0] vertex_slot, corner_a, corner_b, corner_c;
    logic signed [15:0] coord_x, coord_y, coord_z;
    logic result_valid, result_stall;
    logic [ffsl_pkg::LEVEL_W-1:0] light_level;
    logic degenerate;

    face_light_board board;
    int  hold_cycles;
    int  rx_wait;
    bit  rx_random;
    int  live_slots[$];

    face_flat_shade_light_unit dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_stall(item_stall),
        .op(op), .vertex_slot(vertex_slot),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
        .result_valid(result_valid), .result_stall(result_stall),
        .light_level(light_level), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Register write through the setup and access cycles.
    task automatic write_reg(logic [2:0] addr, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_SCALE) board.scale = value & 16'hFFFF;
        else board.bias = value & 16'hFFFF;
    endtask

    // Offers one transaction after a random gap (none with no_gap) and waits until it is taken.
    // Valid stays high after acceptance; the next gap or drain lowers it.
    task automatic send_item(logic opv, int slot, int x, int y, int z,
                             int a, int b, int c, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        op          <= opv;
        vertex_slot <= 10'(slot);
        coord_x     <= 16'(x);
        coord_y     <= 16'(y);
        coord_z     <= 16'(z);
        corner_a    <= 10'(a);
        corner_b    <= 10'(b);
        corner_c    <= 10'(c);
        @(posedge clk);
        while (item_stall) @(posedge clk);
        board.note_item(opv, slot, signed'(16'(x)), signed'(16'(y)), signed'(16'(z)),
                        a, b, c);
    endtask

    task automatic put_vertex(int slot, int x, int y, int z);
        send_item(OP_WRITE, slot, x, y, z,
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 0);
        if (live_slots.size() < 64) live_slots.insert(live_slots.size(), slot);
    endtask

    task automatic shade(int a, int b, int c);
        send_item(OP_SHADE, $urandom_range(0, 1023), $urandom, $urandom, $urandom,
                  a, b, c, 0);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (live_slots.size() < 3 || $urandom_range(0, 2) == 0)
                put_vertex($urandom_range(0, 1023), $urandom_range(0, 65535),
                           $urandom_range(0, 65535),
                           ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535));
            else
                shade(live_slots[$urandom_range(0, live_slots.size() - 1)],
                      live_slots[$urandom_range(0, live_slots.size() - 1)],
                      live_slots[$urandom_range(0, live_slots.size() - 1)]);
        end
    endtask

    // Result side: a random wait after each result when rx_random is set, with a long hold-off when asked.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            rx_wait = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                board.check_result(light_level, degenerate);
                rx_wait = rx_random ? $urandom_range(0, 7) : 0;
            end
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles  <= hold_cycles - 1;
            end
            else if (rx_wait > 0)
            begin
                result_stall <= 1'b1;
                rx_wait = rx_wait - 1;
            end
            else
                result_stall <= 1'b0;
        end
    end

    initial
    begin
        board = new();
        board.reset_regs();
        rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        item_valid = 0; op = 0; vertex_slot = 0;
        coord_x = 0; coord_y = 0; coord_z = 0;
        corner_a = 0; corner_b = 0; corner_c = 0;
        hold_cycles = 0;
        rx_random = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extreme coordinates, a flat face, facing up and down, wide slots.
        put_vertex(0, 0, 0, 0);
        put_vertex(1, 16'h0100, 0, 0);
        put_vertex(2, 0, 16'h0100, 0);
        put_vertex(1023, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        put_vertex(512, 16'h8000, 16'h8000, 16'h8000);
        put_vertex(3, 16'h7FFF, 16'h8000, 16'h0000);
        put_vertex(4, 16'h0200, 0, 0);
        shade(0, 1, 2);
        shade(0, 2, 1);
        shade(0, 1, 4);
        shade(0, 0, 0);
        shade(1023, 512, 3);
        shade(512, 3, 1023);
        shade(0, 1023, 2);
        shade(1, 512, 1023);
        drain();

        // Extreme register settings.
        write_reg(REG_SCALE, 32768);
        write_reg(REG_BIAS, 0);
        shade(0, 1, 2);
        shade(0, 2, 1);
        shade(0, 0, 1);
        drain();
        write_reg(REG_SCALE, 0);
        write_reg(REG_BIAS, 32768);
        shade(0, 1, 2);
        shade(0, 2, 1);
        shade(1, 1, 1);
        drain();
        write_reg(REG_SCALE, 32768);
        write_reg(REG_BIAS, 32768);
        rx_random = 1;
        random_phase(130);
        drain();

        // Long receiver hold-off while the sender keeps offering faces.
        write_reg(REG_SCALE, $urandom_range(0, 32768));
        write_reg(REG_BIAS, $urandom_range(0, 32768));
        hold_cycles = 120;
        repeat (60)
            send_item(OP_SHADE, 0, 0, 0, 0, live_slots[$urandom_range(0, 5)],
                      live_slots[$urandom_range(0, 5)], live_slots[$urandom_range(0, 5)], 1);
        drain();

        write_reg(REG_SCALE, ffsl_pkg::LIGHT_SCALE_RESET);
        write_reg(REG_BIAS, ffsl_pkg::LIGHT_BIAS_RESET);
        random_phase(130);
        drain();
        write_reg(REG_SCALE, $urandom_range(0, 32768));
        write_reg(REG_BIAS, $urandom_range(0, 32768));
        random_phase(100);
        drain();

        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+rtl
rtl/ffsl_pkg.sv
rtl/ffsl_ram.sv
rtl/ffsl_light_pipe.sv
rtl/face_flat_shade_light_unit.sv
tb/face_flat_shade_light_unit_tb.sv
